FILE: src/go_back_n_sender_window_unit_assert.svh
`ifndef GO_BACK_N_SENDER_WINDOW_UNIT_ASSERT_SVH
`define GO_BACK_N_SENDER_WINDOW_UNIT_ASSERT_SVH

// Checks that a consequent holds in the same cycle as its antecedent.
`define GBN_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("window unit check failed");

// Checks that a consequent holds in the cycle after its antecedent.
`define GBN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("window unit check failed");

`endif

FILE: src/gbn_pkg.sv
`timescale 1ns / 1ps

package gbn_pkg;

  // Default window and sequence space sizes.
  localparam int unsigned DEF_WINDOW_DEPTH = 4;
  localparam int unsigned DEF_SEQ_SPACE    = 8;

  // Widths fixed by the item formats.
  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned PKT_SEQ_W = 3;
  localparam int unsigned ACK_W     = 3;

  // Input item kinds.
  localparam logic [1:0] FUNC_SEND    = 2'd0;
  localparam logic [1:0] FUNC_ACK     = 2'd1;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

  // Retransmit timer commands.
  localparam logic [1:0] TMR_NONE    = 2'd0;
  localparam logic [1:0] TMR_START   = 2'd1;
  localparam logic [1:0] TMR_STOP    = 2'd2;
  localparam logic [1:0] TMR_RESTART = 2'd3;

  // One entry of the retransmit buffer.
  typedef struct packed {
    logic [PKT_SEQ_W-1:0] seq;
    logic [PAYLOAD_W-1:0] data;
  } entry_t;

endpackage

FILE: src/gbn_in_if.sv
`timescale 1ns / 1ps

interface gbn_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     func;
  logic [gbn_pkg::PAYLOAD_W-1:0]  payload;
  logic [gbn_pkg::ACK_W-1:0]      ack_number;
  logic                           ack_checksum_ok;

  modport source (output valid, output func, output payload, output ack_number,
                  output ack_checksum_ok, input ready);
  modport sink (input valid, input func, input payload, input ack_number,
                input ack_checksum_ok, output ready);
endinterface

FILE: src/gbn_out_if.sv
`timescale 1ns / 1ps

interface gbn_out_if;
  logic                           valid;
  logic                           ready;
  logic                           has_packet;
  logic [gbn_pkg::PKT_SEQ_W-1:0]  packet_seq;
  logic [gbn_pkg::PAYLOAD_W-1:0]  packet_data;
  logic                           accepted;
  logic [1:0]                     timer_cmd;
  logic                           window_full;
  logic                           last;

  modport source (output valid, output has_packet, output packet_seq, output packet_data,
                  output accepted, output timer_cmd, output window_full, output last,
                  input ready);
  modport sink (input valid, input has_packet, input packet_seq, input packet_data,
                input accepted, input timer_cmd, input window_full, input last,
                output ready);
endinterface

FILE: src/go_back_n_sender_window_unit.sv
`timescale 1ns / 1ps

// Go-Back-N sender window. Payloads taken in by send items are kept with their sequence
// numbers in a retransmit buffer memory and passed on at once unless the window is full;
// valid cumulative acknowledgements slide the window, and a timeout replays the whole
// buffer oldest first. The timer itself lives outside and follows the timer_cmd field.
// Items are handled one at a time: a send, an acknowledgement, an unused code or a timeout
// on an empty buffer is accepted, then executed into the output register; another timeout
// fetches the head entry, then replays the buffer, as the buffer memory has one registered
// read port that delivers one entry per cycle while the output does not stall. Results wait
// in an output register, so a stall on the output holds the execute or replay step that
// would load it. Needs no clearing pass after reset.
module go_back_n_sender_window_unit #(
  parameter int unsigned WINDOW_DEPTH = gbn_pkg::DEF_WINDOW_DEPTH,
  parameter int unsigned SEQ_SPACE    = gbn_pkg::DEF_SEQ_SPACE
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  gbn_in_if.sink       in_i,
  gbn_out_if.source    out_o
);

  localparam int unsigned SEQ_W  = $clog2(SEQ_SPACE);
  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CMP_W  = (SEQ_W > CNT_W) ? SEQ_W : CNT_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_REPLAY = 2'd2;

  // Control state.
  logic [1:0]        state_q, state_d;
  logic [SEQ_W-1:0]  base_q, base_d;
  logic [SEQ_W-1:0]  next_q, next_d;
  logic [SEQ_W-1:0]  head_seq_q, head_seq_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SLOT_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              ov_q, ov_d;

  // Captured input item.
  logic [1:0]                     func_q;
  logic [gbn_pkg::PAYLOAD_W-1:0]  payload_q;
  logic [gbn_pkg::ACK_W-1:0]      ack_q;
  logic                           ok_q;

  // Output register payload.
  logic                           o_has_q, o_has_d;
  logic [gbn_pkg::PKT_SEQ_W-1:0]  o_seq_q, o_seq_d;
  logic [gbn_pkg::PAYLOAD_W-1:0]  o_data_q, o_data_d;
  logic                           o_acc_q, o_acc_d;
  logic [1:0]                     o_tcmd_q, o_tcmd_d;
  logic                           o_full_q, o_full_d;
  logic                           o_last_q, o_last_d;

  // Buffer memory ports.
  logic              wr_en, rd_en;
  logic [SLOT_W-1:0] wr_slot, rd_slot;
  gbn_pkg::entry_t   wr_entry, rd_entry;

  // Datapath helpers.
  logic              in_take, out_free;
  logic [SLOT_W:0]   send_sum, pop_sum, rd_sum;
  logic [SEQ_W:0]    next_sum, base_sum, dist_diff, k_diff;
  logic [3:0]        ack_red;
  logic [SEQ_W-1:0]  ack_m, next_inc, base_new, ack_dist, kdist;
  logic [CNT_W-1:0]  pops, rd_idx, idx_next;
  logic              ack_valid, k_match, is_full;

  assign in_take  = in_i.valid && in_i.ready;
  assign out_free = !ov_q || out_o.ready;
  assign is_full  = (count_q == CNT_W'(WINDOW_DEPTH));
  assign idx_next = idx_q + CNT_W'(1);

  // Slot of the next free entry.
  always_comb begin
    send_sum = {1'b0, head_q} + (SLOT_W + 1)'(count_q);
    if (send_sum >= (SLOT_W + 1)'(WINDOW_DEPTH)) begin
      send_sum = send_sum - (SLOT_W + 1)'(WINDOW_DEPTH);
    end
    wr_slot = send_sum[SLOT_W-1:0];
  end

  // Next sequence number, wrapped.
  always_comb begin
    next_sum = {1'b0, next_q} + (SEQ_W + 1)'(1);
    if (next_sum >= (SEQ_W + 1)'(SEQ_SPACE)) begin
      next_sum = '0;
    end
    next_inc = next_sum[SEQ_W-1:0];
  end

  // Acknowledgement number reduced into the sequence space.
  always_comb begin
    ack_red = {1'b0, ack_q};
    for (int i = 0; i < 4; i++) begin
      if (9'(ack_red) >= 9'(SEQ_SPACE)) begin
        ack_red = ack_red - 4'(SEQ_SPACE);
      end
    end
    ack_m = SEQ_W'(ack_red);
  end

  // Window distance, new base and position of the acknowledged entry.
  always_comb begin
    dist_diff = {1'b0, ack_m} - {1'b0, base_q};
    if (dist_diff[SEQ_W]) begin
      dist_diff = dist_diff + (SEQ_W + 1)'(SEQ_SPACE);
    end
    ack_dist = dist_diff[SEQ_W-1:0];
    ack_valid = ok_q && (CMP_W'(ack_dist) < CMP_W'(WINDOW_DEPTH));

    base_sum = {1'b0, ack_m} + (SEQ_W + 1)'(1);
    if (base_sum >= (SEQ_W + 1)'(SEQ_SPACE)) begin
      base_sum = '0;
    end
    base_new = base_sum[SEQ_W-1:0];

    // Buffered sequence numbers run on from the head entry's number.
    k_diff = {1'b0, ack_m} - {1'b0, head_seq_q};
    if (k_diff[SEQ_W]) begin
      k_diff = k_diff + (SEQ_W + 1)'(SEQ_SPACE);
    end
    kdist   = k_diff[SEQ_W-1:0];
    k_match = (CMP_W'(kdist) < CMP_W'(count_q));
    pops    = k_match ? (CNT_W'(kdist) + CNT_W'(1)) : count_q;

    pop_sum = {1'b0, head_q} + (SLOT_W + 1)'(pops);
    if (pop_sum >= (SLOT_W + 1)'(WINDOW_DEPTH)) begin
      pop_sum = pop_sum - (SLOT_W + 1)'(WINDOW_DEPTH);
    end
  end

  // Read slot for the replay; the first read comes from the execute cycle.
  always_comb begin
    rd_idx = (state_q == ST_EXEC) ? '0 : idx_next;
    rd_sum = {1'b0, head_q} + (SLOT_W + 1)'(rd_idx);
    if (rd_sum >= (SLOT_W + 1)'(WINDOW_DEPTH)) begin
      rd_sum = rd_sum - (SLOT_W + 1)'(WINDOW_DEPTH);
    end
    rd_slot = rd_sum[SLOT_W-1:0];
  end

  // Sequencer and window update.
  always_comb begin
    state_d    = state_q;
    base_d     = base_q;
    next_d     = next_q;
    head_seq_d = head_seq_q;
    count_d    = count_q;
    head_d     = head_q;
    idx_d      = idx_q;
    ov_d       = ov_q && !out_o.ready;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    wr_entry.seq  = gbn_pkg::PKT_SEQ_W'(next_q);
    wr_entry.data = payload_q;
    o_has_d    = o_has_q;
    o_seq_d    = o_seq_q;
    o_data_d   = o_data_q;
    o_acc_d    = o_acc_q;
    o_tcmd_d   = o_tcmd_q;
    o_full_d   = o_full_q;
    o_last_d   = o_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          // Default result: no packet, no timer command, single transaction.
          o_has_d  = 1'b0;
          o_seq_d  = '0;
          o_data_d = '0;
          o_acc_d  = 1'b0;
          o_tcmd_d = gbn_pkg::TMR_NONE;
          o_full_d = is_full;
          o_last_d = 1'b1;
          ov_d     = 1'b1;
          state_d  = ST_IDLE;
          unique case (func_q)
            gbn_pkg::FUNC_SEND: begin
              if (!is_full) begin
                wr_en    = 1'b1;
                count_d  = count_q + CNT_W'(1);
                next_d   = next_inc;
                if (count_q == '0) begin
                  head_seq_d = next_q;
                end
                o_has_d  = 1'b1;
                o_seq_d  = gbn_pkg::PKT_SEQ_W'(next_q);
                o_data_d = payload_q;
                o_acc_d  = 1'b1;
                o_tcmd_d = (base_q == next_q) ? gbn_pkg::TMR_START : gbn_pkg::TMR_NONE;
                o_full_d = (count_q + CNT_W'(1)) == CNT_W'(WINDOW_DEPTH);
              end
            end
            gbn_pkg::FUNC_ACK: begin
              if (ack_valid) begin
                base_d     = base_new;
                head_seq_d = base_new;
                head_d     = pop_sum[SLOT_W-1:0];
                count_d    = count_q - pops;
                o_tcmd_d   = (next_q == base_new) ? gbn_pkg::TMR_STOP : gbn_pkg::TMR_RESTART;
                o_full_d   = (count_q - pops) == CNT_W'(WINDOW_DEPTH);
              end
            end
            gbn_pkg::FUNC_TIMEOUT: begin
              o_tcmd_d = gbn_pkg::TMR_RESTART;
              if (count_q != '0) begin
                // Start the replay: fetch the head entry, emit nothing yet.
                ov_d    = ov_q && !out_o.ready;
                rd_en   = 1'b1;
                idx_d   = '0;
                state_d = ST_REPLAY;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_REPLAY: begin
        if (out_free) begin
          ov_d     = 1'b1;
          o_has_d  = 1'b1;
          o_seq_d  = rd_entry.seq;
          o_data_d = rd_entry.data;
          o_acc_d  = 1'b0;
          o_tcmd_d = (idx_q == '0) ? gbn_pkg::TMR_RESTART : gbn_pkg::TMR_NONE;
          o_full_d = is_full;
          o_last_d = (idx_next == count_q);
          if (idx_next == count_q) begin
            state_d = ST_IDLE;
          end else begin
            rd_en = 1'b1;
            idx_d = idx_next;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      base_q     <= '0;
      next_q     <= '0;
      head_seq_q <= '0;
      count_q    <= '0;
      head_q     <= '0;
      idx_q      <= '0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      base_q     <= base_d;
      next_q     <= next_d;
      head_seq_q <= head_seq_d;
      count_q    <= count_d;
      head_q     <= head_d;
      idx_q      <= idx_d;
      ov_q       <= ov_d;
    end
  end

  // Item capture and output payload.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q    <= in_i.func;
      payload_q <= in_i.payload;
      ack_q     <= in_i.ack_number;
      ok_q      <= in_i.ack_checksum_ok;
    end
    o_has_q  <= o_has_d;
    o_seq_q  <= o_seq_d;
    o_data_q <= o_data_d;
    o_acc_q  <= o_acc_d;
    o_tcmd_q <= o_tcmd_d;
    o_full_q <= o_full_d;
    o_last_q <= o_last_d;
  end

  // Retransmit buffer.
  gbn_buf #(
    .DEPTH  (WINDOW_DEPTH),
    .ADDR_W (SLOT_W)
  ) u_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_slot),
    .wr_data_i (wr_entry),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_slot),
    .rd_data_o (rd_entry)
  );

  // Port drive.
  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = ov_q;
  assign out_o.has_packet  = o_has_q;
  assign out_o.packet_seq  = o_seq_q;
  assign out_o.packet_data = o_data_q;
  assign out_o.accepted    = o_acc_q;
  assign out_o.timer_cmd   = o_tcmd_q;
  assign out_o.window_full = o_full_q;
  assign out_o.last        = o_last_q;

endmodule

FILE: src/gbn_buf.sv
`timescale 1ns / 1ps

module gbn_buf #(
  parameter int unsigned DEPTH  = gbn_pkg::DEF_WINDOW_DEPTH,
  parameter int unsigned ADDR_W = 2
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [ADDR_W-1:0]    wr_addr_i,
  input  gbn_pkg::entry_t      wr_data_i,
  input  logic                 rd_en_i,
  input  logic [ADDR_W-1:0]    rd_addr_i,
  output gbn_pkg::entry_t      rd_data_o
);

  gbn_pkg::entry_t mem [DEPTH];
  gbn_pkg::entry_t rd_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

FILE: src/gbn_checker.sv
`timescale 1ns / 1ps
`include "go_back_n_sender_window_unit_assert.svh"

module gbn_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_has_packet_i,
  input logic       out_accepted_i,
  input logic       out_last_i,
  input logic [1:0] out_timer_cmd_i
);

  // A waiting result transaction stays offered.
  `GBN_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)

  // Items are taken one at a time: ready drops right after an accepted transaction.
  `GBN_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_i, !in_ready_i)

  // While a replay is still under way no new item is taken.
  `GBN_ASSERT_SAME(a_replay_busy, out_valid_i && !out_last_i, !in_ready_i)

  // An accepted send carries its packet in a single result without a stop command.
  `GBN_ASSERT_SAME(a_accept_form, out_valid_i && out_accepted_i, out_has_packet_i && out_last_i && out_timer_cmd_i != gbn_pkg::TMR_STOP)

endmodule

bind go_back_n_sender_window_unit gbn_checker u_gbn_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_has_packet_i (out_o.has_packet),
  .out_accepted_i   (out_o.accepted),
  .out_last_i       (out_o.last),
  .out_timer_cmd_i  (out_o.timer_cmd)
);

FILE: sim/go_back_n_sender_window_unit_tb.sv
`timescale 1ns / 1ps

module go_back_n_sender_window_unit_tb;

  localparam int unsigned DEPTH      = gbn_pkg::DEF_WINDOW_DEPTH;
  localparam int unsigned SPACE      = gbn_pkg::DEF_SEQ_SPACE;
  localparam int unsigned PAY_W      = gbn_pkg::PAYLOAD_W;
  localparam int unsigned SEQ_W      = gbn_pkg::PKT_SEQ_W;
  localparam int unsigned RANDOM_N   = 460;
  localparam int unsigned QUIET_MAX  = 4000;
  localparam int unsigned TAIL_WAIT  = 12;
  localparam int unsigned PRINT_MAX  = 100;
  localparam logic [1:0]  FUNC_SPARE = 2'd3;

  // One input transaction, plus a flag that holds it back until the block has drained.
  typedef struct packed {
    logic [1:0]                 func;
    logic [PAY_W-1:0]           payload;
    logic [gbn_pkg::ACK_W-1:0]  ack_number;
    logic                       ack_ok;
    logic                       drain_first;
  } window_cmd_t;

  // One output transaction.
  typedef struct packed {
    logic             has_packet;
    logic [SEQ_W-1:0] packet_seq;
    logic [PAY_W-1:0] packet_data;
    logic             accepted;
    logic [1:0]       timer_cmd;
    logic             window_full;
    logic             last;
  } window_out_t;

  logic clk_i;
  logic rst_ni;

  gbn_in_if  in_bus ();
  gbn_out_if out_bus ();

  go_back_n_sender_window_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Shadow copy of the sender window.
  int unsigned      base_seq;
  int unsigned      send_seq;
  int unsigned      held_n;
  int unsigned      oldest_slot;
  logic [PAY_W-1:0] buf_data [DEPTH];
  logic [SEQ_W-1:0] buf_seq  [DEPTH];

  window_cmd_t pending_cmds [$];
  window_out_t due_outputs  [$];
  window_cmd_t cmd_on_bus;

  int unsigned cmds_taken;
  int unsigned outputs_seen;
  int unsigned error_count;
  int unsigned refused_sends;
  int unsigned slid_acks;
  int unsigned replayed_packets;
  int unsigned quiet_cycles;

  // Clock generation.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle rates: the receiver idles more first, then the sender, then neither.
  function automatic int unsigned tx_idle_pct();
    if (cmds_taken < 160) return 24;
    else if (cmds_taken < 320) return 47;
    else return 0;
  endfunction

  function automatic int unsigned rx_idle_pct();
    if (cmds_taken < 160) return 47;
    else if (cmds_taken < 320) return 24;
    else return 0;
  endfunction

  function automatic window_cmd_t make_cmd(input logic [1:0] func,
                                           input logic [PAY_W-1:0] payload,
                                           input logic [gbn_pkg::ACK_W-1:0] ack_number,
                                           input logic ack_ok, input logic drain_first);
    window_cmd_t c;
    c.func        = func;
    c.payload     = payload;
    c.ack_number  = ack_number;
    c.ack_ok      = ack_ok;
    c.drain_first = drain_first;
    return c;
  endfunction

  // Appends one transaction to the stimulus queue.
  task automatic add_cmd(input window_cmd_t c);
    pending_cmds = {pending_cmds, c};
  endtask

  // Appends one expected result.
  task automatic add_result(input window_out_t r);
    due_outputs = {due_outputs, r};
  endtask

  // Applies one accepted transaction to the shadow window and queues the outputs it causes.
  task automatic window_step(input window_cmd_t c);
    window_out_t r;
    int unsigned slot;
    int unsigned ack;
    int unsigned gap;
    int unsigned pops;
    logic        found;
    r      = '0;
    r.last = 1'b1;
    case (c.func)
      gbn_pkg::FUNC_SEND: begin
        if (held_n >= DEPTH) begin
          refused_sends++;
        end else begin
          slot           = (oldest_slot + held_n) % DEPTH;
          buf_data[slot] = c.payload;
          buf_seq[slot]  = SEQ_W'(send_seq);
          held_n++;
          r.has_packet   = 1'b1;
          r.packet_seq   = SEQ_W'(send_seq);
          r.packet_data  = c.payload;
          r.accepted     = 1'b1;
          r.timer_cmd    = (base_seq == send_seq) ? gbn_pkg::TMR_START : gbn_pkg::TMR_NONE;
          send_seq       = (send_seq + 1) % SPACE;
        end
        r.window_full = (held_n == DEPTH);
        add_result(r);
      end
      gbn_pkg::FUNC_ACK: begin
        ack = c.ack_number % SPACE;
        gap = (ack + SPACE - base_seq) % SPACE;
        if (c.ack_ok && gap < DEPTH) begin
          slid_acks++;
          base_seq = (ack + 1) % SPACE;
          pops     = held_n;
          found    = 1'b0;
          for (int unsigned k = 0; k < held_n; k++) begin
            if (!found && buf_seq[(oldest_slot + k) % DEPTH] == SEQ_W'(ack)) begin
              pops  = k + 1;
              found = 1'b1;
            end
          end
          oldest_slot = (oldest_slot + pops) % DEPTH;
          held_n      = held_n - pops;
          r.timer_cmd = (send_seq == base_seq) ? gbn_pkg::TMR_STOP : gbn_pkg::TMR_RESTART;
        end
        r.window_full = (held_n == DEPTH);
        add_result(r);
      end
      gbn_pkg::FUNC_TIMEOUT: begin
        r.window_full = (held_n == DEPTH);
        if (held_n == 0) begin
          r.timer_cmd = gbn_pkg::TMR_RESTART;
          add_result(r);
        end else begin
          // Replay the whole buffer oldest first; only the first result restarts the timer.
          for (int unsigned k = 0; k < held_n; k++) begin
            slot          = (oldest_slot + k) % DEPTH;
            r.has_packet  = 1'b1;
            r.packet_seq  = buf_seq[slot];
            r.packet_data = buf_data[slot];
            r.timer_cmd   = (k == 0) ? gbn_pkg::TMR_RESTART : gbn_pkg::TMR_NONE;
            r.last        = (k + 1 == held_n);
            add_result(r);
            replayed_packets++;
          end
        end
      end
      default: begin
        r.window_full = (held_n == DEPTH);
        add_result(r);
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [PAY_W-1:0] got,
                                 input logic [PAY_W-1:0] want);
    error_count++;
    if (error_count <= PRINT_MAX)
      $display("%0t: output %0d: %s: got %0h, want %0h", $time, outputs_seen, what, got, want);
  endtask

  // Input driver: predicts each accepted transaction, then offers the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        window_step(cmd_on_bus);
        cmds_taken <= cmds_taken + 1;
      end
      if (in_bus.valid && !in_bus.ready) begin
        // Hold the current transaction until it is taken.
      end else if (pending_cmds.size() != 0 &&
                   !(pending_cmds[0].drain_first && due_outputs.size() != 0) &&
                   $urandom_range(99) >= tx_idle_pct()) begin
        cmd_on_bus = pending_cmds[0];
        pending_cmds.delete(0);
        in_bus.func            <= cmd_on_bus.func;
        in_bus.payload         <= cmd_on_bus.payload;
        in_bus.ack_number      <= cmd_on_bus.ack_number;
        in_bus.ack_checksum_ok <= cmd_on_bus.ack_ok;
        in_bus.valid           <= 1'b1;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Output monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    window_out_t want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        outputs_seen <= outputs_seen + 1;
        if (due_outputs.size() == 0) begin
          report_mismatch("result with nothing expected", out_bus.packet_data, '0);
        end else begin
          want = due_outputs[0];
          due_outputs.delete(0);
          if (out_bus.has_packet !== want.has_packet)
            report_mismatch("has_packet", out_bus.has_packet, want.has_packet);
          if (out_bus.packet_seq !== want.packet_seq)
            report_mismatch("packet_seq", out_bus.packet_seq, want.packet_seq);
          if (out_bus.packet_data !== want.packet_data)
            report_mismatch("packet_data", out_bus.packet_data, want.packet_data);
          if (out_bus.accepted !== want.accepted)
            report_mismatch("accepted", out_bus.accepted, want.accepted);
          if (out_bus.timer_cmd !== want.timer_cmd)
            report_mismatch("timer_cmd", out_bus.timer_cmd, want.timer_cmd);
          if (out_bus.window_full !== want.window_full)
            report_mismatch("window_full", out_bus.window_full, want.window_full);
          if (out_bus.last !== want.last)
            report_mismatch("last", out_bus.last, want.last);
        end
      end
      out_bus.ready <= ($urandom_range(99) >= rx_idle_pct());
    end
  end

  // Watchdog on cycles in which neither channel moves a transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("timeout after %0d quiet cycles, %0d results still due",
                 quiet_cycles, due_outputs.size());
        $display("go_back_n_sender_window_unit_tb: done, errors");
        $finish;
      end
    end
  end

  // Stimulus: reset, a directed sequence, then random batches built around the live window.
  initial begin : stimulus
    int unsigned counted;
    int unsigned roll;
    int unsigned n;
    logic        drain;
    clk_i                  = 1'b0;
    rst_ni                 = 1'b0;
    in_bus.valid           = 1'b0;
    in_bus.func            = gbn_pkg::FUNC_SEND;
    in_bus.payload         = '0;
    in_bus.ack_number      = '0;
    in_bus.ack_checksum_ok = 1'b0;
    out_bus.ready          = 1'b0;
    base_seq               = 0;
    send_seq               = 0;
    held_n                 = 0;
    oldest_slot            = 0;
    cmds_taken             = 0;
    outputs_seen           = 0;
    error_count            = 0;
    refused_sends          = 0;
    slid_acks              = 0;
    replayed_packets       = 0;
    quiet_cycles           = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty window: timeout, bad checksum, unused code.
    add_cmd(make_cmd(gbn_pkg::FUNC_TIMEOUT, '0, '0, 1'b0, 1'b0));
    add_cmd(make_cmd(gbn_pkg::FUNC_ACK, '0, 3'd0, 1'b0, 1'b0));
    add_cmd(make_cmd(FUNC_SPARE, '0, '0, 1'b0, 1'b0));
    // Fill the window with extreme payloads, then one refused send.
    add_cmd(make_cmd(gbn_pkg::FUNC_SEND, '0, '0, 1'b0, 1'b0));
    add_cmd(make_cmd(gbn_pkg::FUNC_SEND, '1, '0, 1'b0, 1'b0));
    add_cmd(make_cmd(gbn_pkg::FUNC_SEND, {32{2'b10}}, '0, 1'b0, 1'b0));
    add_cmd(make_cmd(gbn_pkg::FUNC_SEND, {32{2'b01}}, '0, 1'b0, 1'b0));
    add_cmd(make_cmd(gbn_pkg::FUNC_SEND, 64'h0123_4567_89ab_cdef, '0, 1'b0, 1'b0));
    // Full replay, an acknowledgement outside the window, then a partial slide.
    add_cmd(make_cmd(gbn_pkg::FUNC_TIMEOUT, '0, '0, 1'b0, 1'b0));
    add_cmd(make_cmd(gbn_pkg::FUNC_ACK, '0, 3'd6, 1'b1, 1'b0));
    add_cmd(make_cmd(gbn_pkg::FUNC_ACK, '0, 3'd1, 1'b1, 1'b0));
    add_cmd(make_cmd(FUNC_SPARE, '1, 3'd7, 1'b1, 1'b0));
    add_cmd(make_cmd(gbn_pkg::FUNC_TIMEOUT, '0, '0, 1'b0, 1'b0));
    // Acknowledge everything outstanding, so the timer stops.
    add_cmd(make_cmd(gbn_pkg::FUNC_ACK, '0, 3'd3, 1'b1, 1'b0));
    add_cmd(make_cmd(gbn_pkg::FUNC_SEND, 64'h8000_0000_0000_0001, '0, 1'b0, 1'b0));
    add_cmd(make_cmd(gbn_pkg::FUNC_SEND, 64'hfedc_ba98_7654_3210, '0, 1'b0, 1'b0));
    // Acknowledgement inside the window that matches no buffered packet.
    add_cmd(make_cmd(gbn_pkg::FUNC_ACK, '0, 3'd7, 1'b1, 1'b0));
    add_cmd(make_cmd(gbn_pkg::FUNC_TIMEOUT, '0, '0, 1'b0, 1'b0));
    add_cmd(make_cmd(gbn_pkg::FUNC_ACK, '0, 3'd0, 1'b1, 1'b0));
    add_cmd(make_cmd(gbn_pkg::FUNC_SEND, '1, '0, 1'b0, 1'b1));

    counted = 0;
    while (counted < RANDOM_N) begin
      while (pending_cmds.size() != 0) @(negedge clk_i);
      drain = (counted % 60 == 0);
      roll  = $urandom_range(99);
      if (roll < 72) begin
        // Well-formed burst: sends, sometimes a timeout, then usually an in-window acknowledgement.
        n = $urandom_range(1, DEPTH + 1);
        for (int unsigned k = 0; k < n; k++) begin
          add_cmd(make_cmd(gbn_pkg::FUNC_SEND, {$urandom, $urandom}, 3'($urandom),
                           1'($urandom), drain && k == 0));
          counted++;
        end
        if ($urandom_range(99) < 25) begin
          add_cmd(make_cmd(gbn_pkg::FUNC_TIMEOUT, {$urandom, $urandom}, 3'($urandom),
                           1'($urandom), 1'b0));
          counted++;
        end
        if ($urandom_range(99) < 80) begin
          add_cmd(make_cmd(gbn_pkg::FUNC_ACK, {$urandom, $urandom},
                           3'((base_seq + $urandom_range(0, DEPTH - 1)) % SPACE),
                           ($urandom_range(99) < 90), 1'b0));
          counted++;
        end
      end else begin
        // Noise: any code, any acknowledgement number, any checksum flag.
        n = $urandom_range(1, 3);
        for (int unsigned k = 0; k < n; k++) begin
          add_cmd(make_cmd(2'($urandom_range(0, 3)), {$urandom, $urandom},
                           3'($urandom), 1'($urandom), drain && k == 0));
          if (pending_cmds[$].func != FUNC_SPARE) counted++;
        end
      end
    end

    // Let everything be taken and answered, then allow for a last replay.
    while (pending_cmds.size() != 0 || in_bus.valid) @(negedge clk_i);
    while (due_outputs.size() != 0) @(negedge clk_i);
    repeat (TAIL_WAIT) @(negedge clk_i);

    $display("covered %0d input transactions and %0d results: %0d refused sends,",
             cmds_taken, outputs_seen, refused_sends);
    $display("  %0d window slides, %0d replayed packets, %0d mismatches",
             slid_acks, replayed_packets, error_count);
    if (error_count == 0)
      $display("go_back_n_sender_window_unit_tb: done, clean");
    else
      $display("go_back_n_sender_window_unit_tb: done, errors");
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/gbn_pkg.sv
src/gbn_in_if.sv
src/gbn_out_if.sv
src/gbn_buf.sv
src/go_back_n_sender_window_unit.sv
src/gbn_checker.sv
sim/go_back_n_sender_window_unit_tb.sv
